[rtl/rpr_pkg.sv]
// Types and constants shared by the rational polyphase resampler.
// No dependencies; rpr_front, rpr_back and the top level import this package.
package rpr_pkg;

   // Fixed field widths and fixed-point format
   localparam int SAMPLE_BITS = 16;
   localparam int COEF_BITS   = 16;
   localparam int FRAC_BITS   = 15;
   localparam int INDEX_BITS  = 8;
   localparam int UP_BITS     = 6;
   localparam int DOWN_BITS   = 7;
   localparam int OFFSET_BITS = 7;

   // Control register port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_UP_FACTOR   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DOWN_FACTOR = CSR_IDX_W'(1);

   typedef enum logic [0:0] {
      OP_COEF   = 1'b0,
      OP_SAMPLE = 1'b1
   } opcode_type;

   // Request word as it arrives on the input queue
   typedef struct packed {
      opcode_type                    opcode;
      logic signed [SAMPLE_BITS-1:0] in_sample;
      logic [INDEX_BITS-1:0]         coef_index;
      logic signed [COEF_BITS-1:0]   coef_value;
   } req_type;

   // Response word
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] out_sample;
      logic                          last_of_run;
   } rsp_type;

   // Classified command handed from the front end to the engine
   typedef struct packed {
      opcode_type                  op;
      logic                        coef_ok;
      logic signed [COEF_BITS-1:0] data;
      logic [INDEX_BITS-1:0]       index;
   } cmd_type;

endpackage

[rtl/rpr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/rpr_front.sv]
// Front end: accepts request words, classifies them and queues commands.
// Depends on rpr_pkg.
module rpr_front
   import rpr_pkg::*;
#(
   parameter int TAP_COUNT = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    clearing,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    cmd_valid,
   output cmd_type cmd_data,
   input  logic    cmd_pop
);

   cmd_type    q_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    cmd_new;
   logic       push, pop;

   // Classify the incoming word
   always_comb begin
      cmd_new.op      = req_data.opcode;
      cmd_new.index   = req_data.coef_index;
      cmd_new.coef_ok = 1'b0;
      cmd_new.data    = req_data.coef_value;
      case (req_data.opcode)
         OP_SAMPLE: begin
            cmd_new.data = req_data.in_sample;
         end
         OP_COEF: begin
            cmd_new.coef_ok = (32'(req_data.coef_index) < TAP_COUNT);
         end
         default: begin
            cmd_new.data = req_data.coef_value;
         end
      endcase
   end

   // Hold off requests while the queue is full or history is being cleared
   assign req_full  = (cnt_ff == 2'd2) || clearing;
   assign push      = req_push && !req_full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd_data  = q_ff[rd_ff];

   // Advance queue pointers
   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= cmd_new;
      end
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[rtl/rpr_back.sv]
// Engine: clears history, writes coefficients, runs the polyphase MAC and
// queues response words. Depends on rpr_pkg and rpr_ram.
module rpr_back
   import rpr_pkg::*;
#(
   parameter int TAP_COUNT = 256,
   parameter int MAX_UP    = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [UP_BITS-1:0]   up_factor,
   input  logic [DOWN_BITS-1:0] down_factor,
   input  logic                 cmd_valid,
   input  cmd_type              cmd_data,
   output logic                 cmd_pop,
   output logic                 clearing,
   output logic                 rsp_empty,
   output rsp_type              rsp_data,
   input  logic                 rsp_pop
);

   localparam int AW       = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
   localparam int UW       = $clog2(MAX_UP + 1);
   localparam int PW       = ((AW > UW) ? AW : UW) + 2;
   localparam int JW       = $clog2(TAP_COUNT + MAX_UP + 1);
   localparam int PROD_W   = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_W    = PROD_W + AW + 1;
   localparam int SCALED_W = ACC_W + UW + 1;
   localparam logic signed [SCALED_W-1:0] ROUND_HALF = SCALED_W'(1 << (FRAC_BITS - 1));
   localparam logic signed [SCALED_W-1:0] SAT_HI = SCALED_W'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [SCALED_W-1:0] SAT_LO = -SAT_HI - SCALED_W'(1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_MAC,
      ST_SCALE,
      ST_ROUND,
      ST_PUSH
   } state_type;

   state_type                    state_ff, state_in;
   logic [AW-1:0]                clr_ff, clr_in;
   logic [AW-1:0]                head_ff, head_in;
   logic [OFFSET_BITS-1:0]       ofs_ff, ofs_in;
   logic [7:0]                   o_ff, o_in;
   logic [JW-1:0]                j_ff, j_in;
   logic [AW-1:0]                pos_ff, pos_in;
   logic                         rd_vld_ff, rd_vld_in;
   logic                         prod_vld_ff, prod_vld_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic signed [SCALED_W-1:0]   scaled_ff, scaled_in;
   rsp_type                      res_ff, res_in;

   // Response queue
   rsp_type    q_ff [2];
   logic       q_wr_ff, q_wr_in;
   logic       q_rd_ff, q_rd_in;
   logic [1:0] q_cnt_ff, q_cnt_in;
   logic       q_push, q_pop;

   // Effective factors
   logic [UW-1:0]        u_eff;
   logic [DOWN_BITS-1:0] d_eff;

   // Memory ports
   logic                   hist_we, coef_we;
   logic [AW-1:0]          hist_waddr, coef_waddr, hist_raddr, coef_raddr;
   logic [SAMPLE_BITS-1:0] hist_wdata, hist_rdata;
   logic [COEF_BITS-1:0]   coef_wdata, coef_rdata;

   // Datapath helpers
   logic [AW:0]                head_inc;
   logic [AW-1:0]              head_nx;
   logic [PW-1:0]              pos_x, u_p, pos_step;
   logic                       issue_en;
   logic signed [SCALED_W-1:0] acc_x, u_x, rnd, shifted;
   logic [8:0]                 o_next;

   // Clamp the factors: zero acts as one, up factor limited to MAX_UP
   always_comb begin
      if (up_factor == '0) begin
         u_eff = UW'(1);
      end else if (32'(up_factor) > MAX_UP) begin
         u_eff = UW'(MAX_UP);
      end else begin
         u_eff = UW'(up_factor);
      end
      d_eff = (down_factor == '0) ? DOWN_BITS'(1) : down_factor;
   end

   rpr_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(TAP_COUNT)) u_hist (
      .clock (clock),
      .we    (hist_we),
      .waddr (hist_waddr),
      .wdata (hist_wdata),
      .raddr (hist_raddr),
      .rdata (hist_rdata)
   );

   rpr_ram #(.WIDTH(COEF_BITS), .DEPTH(TAP_COUNT)) u_coef (
      .clock (clock),
      .we    (coef_we),
      .waddr (coef_waddr),
      .wdata (coef_wdata),
      .raddr (coef_raddr),
      .rdata (coef_rdata)
   );

   assign head_inc = {1'b0, head_ff} + 1'b1;
   assign head_nx  = (32'(head_inc) >= TAP_COUNT) ? '0 : head_inc[AW-1:0];

   // Step back through history by the up factor, wrapping around
   assign pos_x    = PW'(pos_ff);
   assign u_p      = PW'(u_eff);
   assign pos_step = (pos_x >= u_p) ? pos_x - u_p : pos_x + PW'(TAP_COUNT) - u_p;

   assign issue_en   = (state_ff == ST_MAC) && (32'(j_ff) < TAP_COUNT);
   assign hist_raddr = pos_ff;
   assign coef_raddr = AW'(j_ff);

   assign acc_x   = SCALED_W'(acc_ff);
   assign u_x     = $signed(SCALED_W'(u_eff));
   assign rnd     = scaled_ff + ROUND_HALF;
   assign shifted = rnd >>> FRAC_BITS;
   assign o_next  = 9'(o_ff) + 9'(d_eff);

   assign q_push    = (state_ff == ST_PUSH) && (q_cnt_ff != 2'd2);
   assign rsp_empty = (q_cnt_ff == 2'd0);
   assign q_pop     = rsp_pop && !rsp_empty;
   assign rsp_data  = q_ff[q_rd_ff];
   assign clearing  = (state_ff == ST_CLEAR);
   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid;

   // Next-state and datapath logic
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      head_in     = head_ff;
      ofs_in      = ofs_ff;
      o_in        = o_ff;
      j_in        = j_ff;
      pos_in      = pos_ff;
      rd_vld_in   = issue_en;
      prod_vld_in = rd_vld_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      scaled_in   = scaled_ff;
      res_in      = res_ff;
      hist_we     = 1'b0;
      hist_waddr  = head_nx;
      hist_wdata  = cmd_data.data;
      coef_we     = 1'b0;
      coef_waddr  = AW'(cmd_data.index);
      coef_wdata  = cmd_data.data;

      // Multiply stage and accumulate stage of the MAC pipeline
      if (rd_vld_ff) begin
         prod_in = $signed(coef_rdata) * $signed(hist_rdata);
      end
      if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end

      case (state_ff)
         ST_CLEAR: begin
            hist_we    = 1'b1;
            hist_waddr = clr_ff;
            hist_wdata = '0;
            if (clr_ff == AW'(TAP_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd_data.op)
                  OP_SAMPLE: begin
                     hist_we  = 1'b1;
                     head_in  = head_nx;
                     o_in     = {1'b0, ofs_ff};
                     state_in = ST_CHECK;
                  end
                  default: begin
                     coef_we = cmd_data.coef_ok;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            // Start the next output of this span, or close the span
            if (9'(o_ff) < 9'(u_eff)) begin
               j_in     = JW'(o_ff);
               pos_in   = head_ff;
               acc_in   = '0;
               state_in = ST_MAC;
            end else begin
               ofs_in   = OFFSET_BITS'(o_ff - 8'(u_eff));
               state_in = ST_IDLE;
            end
         end
         ST_MAC: begin
            if (issue_en) begin
               j_in   = j_ff + JW'(u_eff);
               pos_in = AW'(pos_step);
            end else if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            scaled_in = acc_x * u_x;
            state_in  = ST_ROUND;
         end
         ST_ROUND: begin
            // Round half up from Q1.15 and saturate
            if (shifted > SAT_HI) begin
               res_in.out_sample = SAMPLE_BITS'(SAT_HI);
            end else if (shifted < SAT_LO) begin
               res_in.out_sample = SAMPLE_BITS'(SAT_LO);
            end else begin
               res_in.out_sample = SAMPLE_BITS'(shifted);
            end
            res_in.last_of_run = (o_next >= 9'(u_eff));
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (q_push) begin
               o_in     = o_next[7:0];
               state_in = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      q_wr_in  = q_push ? !q_wr_ff : q_wr_ff;
      q_rd_in  = q_pop ? !q_rd_ff : q_rd_ff;
      q_cnt_in = q_cnt_ff + {1'b0, q_push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      o_ff      <= o_in;
      j_ff      <= j_in;
      pos_ff    <= pos_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      scaled_ff <= scaled_in;
      res_ff    <= res_in;
      if (q_push) begin
         q_ff[q_wr_ff] <= res_ff;
      end
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         head_ff     <= '0;
         ofs_ff      <= '0;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         q_wr_ff     <= 1'b0;
         q_rd_ff     <= 1'b0;
         q_cnt_ff    <= 2'd0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         head_ff     <= head_in;
         ofs_ff      <= ofs_in;
         rd_vld_ff   <= rd_vld_in;
         prod_vld_ff <= prod_vld_in;
         q_wr_ff     <= q_wr_in;
         q_rd_ff     <= q_rd_in;
         q_cnt_ff    <= q_cnt_in;
      end
   end

endmodule

[rtl/rational_polyphase_resampler.sv]
// Top level of the rational polyphase resampler: control registers, front end
// and engine. Depends on rpr_pkg, rpr_front, rpr_back (and rpr_ram below it).
//
//   channel  direction  handshake            word
//   req_     in         push / full          req_type (coefficient or sample)
//   rsp_     out        pop / empty          rsp_type (sample, last of run)
//   csr_     in         valid / ready        index + data (up, down factor)
//
// A coefficient word is written from the idle state. A sample word is written to
// history and then, for each output in its span, the engine steps through check,
// MAC over every U-th tap from phase p, pipeline drain, scale, round and push,
// all through the single shared multiply-accumulate.
// After reset the history is cleared with req_full high.
// A full response queue stalls the engine; a full command queue raises req_full.
module rational_polyphase_resampler
   import rpr_pkg::*;
#(
   parameter int TAP_COUNT = 256,
   parameter int MAX_UP    = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [UP_BITS-1:0]   up_ff, up_in;
   logic [DOWN_BITS-1:0] down_ff, down_in;
   logic                 cmd_valid, cmd_pop, clearing;
   cmd_type              cmd_data;

   // Control registers always take a write
   assign csr_ready = 1'b1;

   always_comb begin
      up_in   = up_ff;
      down_in = down_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_UP_FACTOR: begin
               up_in = csr_data[UP_BITS-1:0];
            end
            CSR_DOWN_FACTOR: begin
               down_in = csr_data[DOWN_BITS-1:0];
            end
            default: begin
               up_in = up_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff   <= UP_BITS'(1);
         down_ff <= DOWN_BITS'(1);
      end else begin
         up_ff   <= up_in;
         down_ff <= down_in;
      end
   end

   rpr_front #(.TAP_COUNT(TAP_COUNT)) u_front (
      .clock     (clock),
      .reset     (reset),
      .clearing  (clearing),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   rpr_back #(.TAP_COUNT(TAP_COUNT), .MAX_UP(MAX_UP)) u_back (
      .clock       (clock),
      .reset       (reset),
      .up_factor   (up_ff),
      .down_factor (down_ff),
      .cmd_valid   (cmd_valid),
      .cmd_data    (cmd_data),
      .cmd_pop     (cmd_pop),
      .clearing    (clearing),
      .rsp_empty   (rsp_empty),
      .rsp_data    (rsp_data),
      .rsp_pop     (rsp_pop)
   );

`ifndef SYNTHESIS
   // No word enters while history is being cleared
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      clearing |-> req_full)
      else $error("request accepted during history clear");

   // Clearing only follows reset, so no response can be waiting then
   a_clear_no_rsp: assert property (@(posedge clock) disable iff (reset)
      clearing |-> rsp_empty)
      else $error("response pending during history clear");

   // Clearing never restarts outside reset
   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      !$rose(clearing))
      else $error("history clear restarted");
`endif

endmodule
